[rtl/sha256_pkg.sv]
// shared types, constants and round functions of the sha-256 message hasher
// used by sha256_sched, sha256_round and sha256_message_hasher_core
package sha256_pkg;

  typedef logic [7:0][31:0] word8_t;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FIN,
    ST_PAD,
    ST_DONE
  } state_e;

  // control of the block buffer / message schedule
  typedef struct packed {
    logic push;  // shift one byte into the block buffer
    logic step;  // advance the schedule by one round
  } sched_ctl_t;

  // control of the round unit
  typedef struct packed {
    logic step;   // run one compression round
    logic first;  // take a..h from the chaining words
  } round_ctl_t;

  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [5:0] LEN_POS      = 6'd56;
  localparam logic [5:0] LAST_POS     = 6'd63;
  localparam logic [5:0] LAST_ROUND   = 6'd63;
  localparam logic [2:0] LAST_WORD    = 3'd7;

  // initial hash values, word 0 in the lowest slot
  localparam word8_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] big0(input logic [31:0] v);
    return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] v);
    return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
  endfunction

  function automatic logic [31:0] small0(input logic [31:0] v);
    return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
  endfunction

  function automatic logic [31:0] small1(input logic [31:0] v);
    return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'b0, v[31:10]};
  endfunction

  // round constants
  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

[rtl/sha256_sched.sv]
// block buffer and rolling message schedule of the sha-256 hasher
// bytes shift in one at a time, rounds shift out one schedule word each
// depends on sha256_pkg
module sha256_sched import sha256_pkg::*; (
  input  logic        clk_i,
  input  sched_ctl_t  ctl_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] wt_o
);

  // word j of the block sits at bits [511-32j -: 32]
  logic [511:0] buf_q, buf_d;
  logic [31:0]  w_new;

  // next schedule word from w[t], w[t+1], w[t+9], w[t+14]
  assign w_new = buf_q[511:480] + small0(buf_q[479:448]) + buf_q[223:192]
               + small1(buf_q[63:32]);
  assign wt_o  = buf_q[511:480];

  // byte load or schedule step
  always_comb begin
    buf_d = buf_q;
    if (ctl_i.push) begin
      buf_d = {buf_q[503:0], byte_i};
    end else if (ctl_i.step) begin
      buf_d = {buf_q[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

[rtl/sha256_round.sv]
// shared compression round unit of the sha-256 hasher with working words a..h
// depends on sha256_pkg
module sha256_round import sha256_pkg::*; (
  input  logic        clk_i,
  input  round_ctl_t  ctl_i,
  input  word8_t      chain_i,
  input  logic [31:0] wt_i,
  input  logic [31:0] kt_i,
  output word8_t      work_o
);

  word8_t      work_q, work_d, src;
  logic [31:0] t1, t2, chs, mj;

  // one round, first round starts from the chaining words
  always_comb begin
    src    = ctl_i.first ? chain_i : work_q;
    chs    = (src[4] & src[5]) ^ (~src[4] & src[6]);
    mj     = (src[0] & src[1]) ^ (src[0] & src[2]) ^ (src[1] & src[2]);
    t1     = src[7] + big1(src[4]) + chs + kt_i + wt_i;
    t2     = big0(src[0]) + mj;
    work_d = work_q;
    work_d[7] = src[6];
    work_d[6] = src[5];
    work_d[5] = src[4];
    work_d[4] = src[3] + t1;
    work_d[3] = src[2];
    work_d[2] = src[1];
    work_d[1] = src[0];
    work_d[0] = t1 + t2;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step) begin
      work_q <= work_d;
    end
  end

  assign work_o = work_q;

endmodule

[rtl/sha256_message_hasher_core.sv]
// sha-256 message hasher: one byte per request, 8 digest words per message.
// a byte request is taken in ST_IDLE; the 64th byte of a block adds 64 rounds of the
// shared round unit (ST_COMP) plus a chaining step (ST_FIN).
// an end request pads one byte a cycle (up to 72 bytes) with a compression per
// block, then ST_DONE hands the digest to the free output buffer, 8 words follow.
// reset loads the initial hash values and clears counters and control state.
module sha256_message_hasher_core import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] msg_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast_o    // last_word
);

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] len_q, len_d;
  logic        pad_q, pad_d;
  logic        mark_q, mark_d;
  logic        lenok_q, lenok_d;
  logic        final_q, final_d;
  logic [5:0]  rnd_q, rnd_d;
  word8_t      chain_q, chain_d;
  word8_t      obuf_q, obuf_d;
  logic        ovalid_q, ovalid_d;
  logic [2:0]  ocnt_q, ocnt_d;

  sched_ctl_t  sched_ctl;
  round_ctl_t  round_ctl;
  logic [7:0]  push_byte;
  logic [7:0]  pad_byte;
  logic [7:0]  len_byte;
  logic [63:0] len_bits;
  logic [31:0] wt;
  word8_t      work;
  logic        in_acc;
  logic        out_acc;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // big-endian bit count byte for buffer positions 56..63
  always_comb begin
    len_bits = {len_q, 3'b000} >> {LAST_WORD - fill_q[2:0], 3'b000};
    len_byte = len_bits[7:0];
  end

  // padding byte: marker, then zeros, then the bit count in the final block
  always_comb begin
    if (!mark_q) begin
      pad_byte = PAD_MARK;
    end else if (lenok_q && (fill_q >= LEN_POS)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign push_byte = (state_q == ST_PAD) ? pad_byte : s_axis_tdata_i;

  // sequencer
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    len_d     = len_q;
    pad_d     = pad_q;
    mark_d    = mark_q;
    lenok_d   = lenok_q;
    final_d   = final_q;
    rnd_d     = rnd_q;
    chain_d   = chain_q;
    obuf_d    = obuf_q;
    ovalid_d  = ovalid_q;
    ocnt_d    = ocnt_q;
    sched_ctl = '0;
    round_ctl = '0;
    s_axis_tready_o = 1'b0;

    // output buffer drain
    if (out_acc) begin
      ocnt_d = ocnt_q + 3'd1;
      if (ocnt_q == LAST_WORD) begin
        ovalid_d = 1'b0;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_acc) begin
          if (s_axis_tuser_i) begin
            sched_ctl.push = 1'b1;
            fill_d = fill_q + 6'd1;
            len_d  = len_q + 61'd1;
          end
          pad_d = s_axis_tlast_i;
          if (s_axis_tuser_i && (fill_q == LAST_POS)) begin
            rnd_d   = '0;
            state_d = ST_COMP;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        sched_ctl.push = 1'b1;
        fill_d = fill_q + 6'd1;
        if (!mark_q) begin
          mark_d  = 1'b1;
          lenok_d = (fill_q < LEN_POS);
        end
        if (fill_q == LAST_POS) begin
          final_d = mark_q && lenok_q;
          lenok_d = 1'b1;
          rnd_d   = '0;
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        sched_ctl.step  = 1'b1;
        round_ctl.step  = 1'b1;
        round_ctl.first = (rnd_q == '0);
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == LAST_ROUND) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        for (int j = 0; j < 8; j++) begin
          chain_d[j] = chain_q[j] + work[j];
        end
        if (final_q) begin
          state_d = ST_DONE;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DONE: begin
        // wait for the previous digest to drain
        if (!ovalid_q) begin
          obuf_d   = chain_q;
          ovalid_d = 1'b1;
          ocnt_d   = '0;
          chain_d  = H_INIT;
          fill_d   = '0;
          len_d    = '0;
          pad_d    = 1'b0;
          mark_d   = 1'b0;
          lenok_d  = 1'b0;
          final_d  = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      len_q    <= '0;
      pad_q    <= 1'b0;
      mark_q   <= 1'b0;
      lenok_q  <= 1'b0;
      final_q  <= 1'b0;
      rnd_q    <= '0;
      chain_q  <= H_INIT;
      ovalid_q <= 1'b0;
      ocnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      len_q    <= len_d;
      pad_q    <= pad_d;
      mark_q   <= mark_d;
      lenok_q  <= lenok_d;
      final_q  <= final_d;
      rnd_q    <= rnd_d;
      chain_q  <= chain_d;
      ovalid_q <= ovalid_d;
      ocnt_q   <= ocnt_d;
    end
  end

  // digest buffer payload
  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
  end

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctl_i  (sched_ctl),
    .byte_i (push_byte),
    .wt_o   (wt)
  );

  sha256_round u_round (
    .clk_i   (clk_i),
    .ctl_i   (round_ctl),
    .chain_i (chain_q),
    .wt_i    (wt),
    .kt_i    (round_k(rnd_q)),
    .work_o  (work)
  );

  // result channel
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {5'b0, ocnt_q, obuf_q[ocnt_q]};
  assign m_axis_tlast_o  = (ocnt_q == LAST_WORD);

endmodule

[dv/sha256_digest_checker.sv]
// checker for the sha-256 message hasher: watches both stream channels,
// predicts the digest words of each message and compares them in order
// self-contained, needs only the clock, reset and the port signals of the core
module sha256_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] msg_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,   // end_of_message
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,   // [31:0] digest_word, [34:32] word_index
  input  logic        m_axis_tlast_i,   // last_word
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam int         LEN_SLOT  = 56;   // first byte of the bit count field
  localparam logic [2:0] FINAL_IDX = 3'd7;

  localparam logic [0:7][31:0] HASH_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  // predicted hasher state
  logic [0:7][31:0]  chain_h;
  logic [0:63][7:0]  block_buf;
  logic [5:0]        fill_cnt;
  logic [60:0]       byte_len;
  digest_beat_t      digest_q[$];
  int                mismatches;

  assign fail_count_o = mismatches;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // one 64-round compression of block_buf into chain_h
  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] x15, x2, wr, t1, t2;
    for (int j = 0; j < 16; j++)
      w[j] = {block_buf[4*j], block_buf[4*j+1], block_buf[4*j+2], block_buf[4*j+3]};
    {a, b, c, d, e, f, g, h} = chain_h;
    for (int r = 0; r < 64; r++) begin
      if (r >= 16) begin
        x15 = w[(r - 15) & 15];
        x2  = w[(r - 2) & 15];
        w[r & 15] = w[r & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                  + w[(r - 7) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
      end
      wr = w[r & 15];
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[r] + wr;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endtask

  // take one request into the prediction, queue the digest on end of message
  task automatic absorb_request(input logic [7:0] msg_byte, input logic has_byte,
                                input logic eom);
    logic [63:0]  bit_len;
    digest_beat_t beat;
    if (has_byte) begin
      block_buf[fill_cnt] = msg_byte;
      fill_cnt++;
      byte_len++;
      if (fill_cnt == 0) compress_block();
    end
    if (!eom) return;

    // padding: marker, zeros, spill into a second block when the count won't fit
    block_buf[fill_cnt] = PAD_BYTE;
    for (int j = int'(fill_cnt) + 1; j < 64; j++) block_buf[j] = 8'h00;
    if (int'(fill_cnt) >= LEN_SLOT) begin
      compress_block();
      block_buf = '0;
    end
    bit_len = {byte_len, 3'b000};
    for (int j = 0; j < 8; j++) block_buf[LEN_SLOT + j] = bit_len[63 - 8*j -: 8];
    compress_block();

    for (int j = 0; j < 8; j++) begin
      beat.word = chain_h[j];
      beat.idx  = 3'(j);
      beat.last = (3'(j) == FINAL_IDX);
      digest_q  = {digest_q, beat};
    end
    chain_h  = HASH_IV;
    fill_cnt = '0;
    byte_len = '0;
  endtask

  // sample both channels at the clock edge
  always @(posedge clk_i) begin : watch
    digest_beat_t want;
    if (!rst_ni) begin
      chain_h    = HASH_IV;
      block_buf  = '0;
      fill_cnt   = '0;
      byte_len   = '0;
      mismatches = 0;
      digest_q.delete();
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        absorb_request(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (digest_q.size() == 0) begin
          mismatches++;
          if (mismatches < 100)
            $display("%0t: unexpected digest word %h index %0d last %b", $time,
                     m_axis_tdata_i[31:0], m_axis_tdata_i[34:32], m_axis_tlast_i);
        end else begin
          want = digest_q.pop_front();
          if (m_axis_tdata_i[31:0] !== want.word || m_axis_tdata_i[34:32] !== want.idx ||
              m_axis_tlast_i !== want.last || m_axis_tdata_i[39:35] !== 5'b0) begin
            mismatches++;
            if (mismatches < 100)
              $display("%0t: digest mismatch: expected word %h index %0d last %b pad 00,",
                       $time, want.word, want.idx, want.last,
                       " got word %h index %0d last %b pad %h", m_axis_tdata_i[31:0],
                       m_axis_tdata_i[34:32], m_axis_tlast_i, m_axis_tdata_i[39:35]);
          end
        end
      end
    end
    pending_o <= digest_q.size();
  end

endmodule

[dv/sha256_message_hasher_core_tb.sv]
// testbench top for sha256_message_hasher_core: clock, reset, message requests
// with bursty timing and a stalling receiver; checking is in sha256_digest_checker
// depends on rtl/sha256_pkg.sv, rtl/sha256_message_hasher_core.sv and the checker
module sha256_message_hasher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 75;
  localparam int MIN_MSGS    = 4;
  localparam int LONG_HOLD   = 600;     // receiver hold-off, in cycles
  localparam int DRAIN       = 400;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] msg_byte
  logic        s_axis_tuser;   // [0] has_byte
  logic        s_axis_tlast;   // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] digest_word, [34:32] word_index
  logic        m_axis_tlast;   // last_word
  int          fail_count;
  int          pending;
  int          burst_left;
  int          cycle_cnt;
  bit          hold_armed;

  sha256_message_hasher_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  sha256_digest_checker checker_u (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("sha256_message_hasher_core test failed");
      $finish;
    end
  end

  // offer one request, opening a new burst after a random gap when one runs out
  task automatic send_request(input logic [7:0] msg_byte, input logic has_byte,
                              input logic eom);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= msg_byte;
    s_axis_tuser  <= has_byte;
    s_axis_tlast  <= eom;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // receiver: random stall pattern, plus one long hold-off when armed
  initial begin
    int mode;
    int mode_left;
    m_axis_tready = 1'b0;
    mode_left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 64);
      end
      mode_left--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // stimulus and verdict
  initial begin
    int         msg_len;
    int         body;
    int         rand_items;
    int         n_msgs;
    logic       end_byte;
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    hold_armed    = 1'b0;
    burst_left    = 0;
    rand_items    = 0;
    n_msgs        = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message
    send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    // empty request ahead of "abc"
    send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    // single extreme bytes
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    // empty request inside a message, end request without a byte
    send_request(8'h55, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'haa, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    // mixed extremes
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h7f, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h01, 1'b1, 1'b1);

    // random messages; the receiver holds off at the start so the core backs up
    hold_armed = 1'b1;
    while (rand_items < RAND_ITEMS || n_msgs < MIN_MSGS) begin
      case ($urandom_range(0, 7))
        0: begin
          case ($urandom_range(0, 5))
            0: msg_len = 55;
            1: msg_len = 56;
            2: msg_len = 63;
            3: msg_len = 64;
            4: msg_len = 65;
            default: msg_len = $urandom_range(119, 128);
          endcase
        end
        1: msg_len = $urandom_range(0, 3);
        default: msg_len = $urandom_range(1, 24);
      endcase
      end_byte = (msg_len != 0) && ($urandom_range(0, 3) != 0);
      body = end_byte ? msg_len - 1 : msg_len;
      for (int i = 0; i < body; i++) begin
        if ($urandom_range(0, 9) == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        rand_items++;
      end
      send_request(8'($urandom_range(0, 255)), end_byte, 1'b1);
      rand_items++;
      n_msgs++;
      // stray empty request between messages
      if ($urandom_range(0, 4) == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
    s_axis_tvalid <= 1'b0;

    // wait for the last digest, then let the core settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("sha256_message_hasher_core test passed");
    else
      $display("sha256_message_hasher_core test failed");
    $finish;
  end

endmodule

[files.f]
rtl/sha256_pkg.sv
rtl/sha256_sched.sv
rtl/sha256_round.sv
rtl/sha256_message_hasher_core.sv
dv/sha256_digest_checker.sv
dv/sha256_message_hasher_core_tb.sv
